>>> sv/pfan_pkg.sv
// Package for the polygon fan triangulator: sizes, corner and result types,
// and the command and status structs between controller and datapath.
// Used by every module of the block but pfan_ram; depends on nothing.
package pfan_pkg;

    localparam int MAX_POLYGON_CORNERS = 64;
    localparam int INDEX_BITS          = 24;

    localparam int FILL_W   = $clog2(MAX_POLYGON_CORNERS + 1);
    localparam int ADDR_W   = $clog2(MAX_POLYGON_CORNERS);
    localparam int RAW_W    = INDEX_BITS + 1;
    localparam int MAT_W    = 8;
    localparam int COUNT_W  = 3;
    localparam int FACE_MAX = 4;
    localparam int TRI_N    = 3;

    localparam int IN_TDATA_W  = ((RAW_W + MAT_W + 7) / 8) * 8;
    localparam int OUT_BITS    = 8 * INDEX_BITS + COUNT_W + MAT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [INDEX_BITS-1:0] vtx;
        logic [INDEX_BITS-1:0] pos;
    } t_corner;

    typedef enum logic [1:0] {
        KIND_DROP,
        KIND_ERR,
        KIND_FACE,
        KIND_FAN
    } t_close_kind;

    typedef struct packed {
        logic in_ready;
        logic rd_issue;
        logic load_fan;
        logic load_single;
    } t_dp_cmd;

    typedef struct packed {
        logic        close_fire;
        t_close_kind kind;
        logic        fan_last;
        logic        out_free;
    } t_dp_status;

endpackage

>>> sv/pfan_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the corner buffer of the triangulator; no package dependency.
module pfan_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/pfan_ctrl.sv
// Controller state machine of the triangulator: sequences entry intake,
// single results and the fan read/load loop. Depends on pfan_pkg.
module pfan_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfan_pkg::t_dp_status i_status,
    output pfan_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_TAKE,
        S_SINGLE,
        S_READ,
        S_FAN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        case (r_state)
            S_TAKE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.close_fire) begin
                    case (i_status.kind)
                        pfan_pkg::KIND_ERR:  n_state = S_SINGLE;
                        pfan_pkg::KIND_FACE: n_state = S_SINGLE;
                        pfan_pkg::KIND_FAN:  n_state = S_READ;
                        default:             n_state = S_TAKE;
                    endcase
                end
            end
            S_SINGLE: begin
                if (i_status.out_free) begin
                    o_cmd.load_single = 1'b1;
                    n_state           = S_TAKE;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_FAN;
            end
            S_FAN: begin
                if (i_status.out_free) begin
                    o_cmd.load_fan = 1'b1;
                    n_state        = i_status.fan_last ? S_TAKE : S_READ;
                end
            end
            default: n_state = S_TAKE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/pfan_datapath.sv
// Datapath of the triangulator: position counter, corner buffer RAM, first
// four corners in registers, and the output register. Depends on pfan_pkg
// and pfan_ram.
module pfan_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pfan_pkg::t_dp_cmd                   i_cmd,
    output pfan_pkg::t_dp_status                o_status,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_data,
    input  logic                                i_in_valid,
    input  logic signed [pfan_pkg::RAW_W-1:0]   i_raw_index,
    input  logic [pfan_pkg::MAT_W-1:0]          i_material,
    input  logic                                i_start_of_mesh,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [pfan_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic                                o_out_last,
    output logic                                o_out_error
);

    logic                            r_mode;
    logic [pfan_pkg::INDEX_BITS-1:0] r_pos;
    logic [pfan_pkg::FILL_W-1:0]     r_fill;
    logic                            r_ovf;
    pfan_pkg::t_corner               r_c [pfan_pkg::FACE_MAX];
    pfan_pkg::t_corner               r_prev;
    logic [pfan_pkg::FILL_W-1:0]     r_n;
    logic [pfan_pkg::FILL_W-1:0]     r_idx;
    logic                            r_err;
    logic [pfan_pkg::MAT_W-1:0]      r_mat;

    logic                            r_o_valid;
    pfan_pkg::t_corner               r_o_c [pfan_pkg::FACE_MAX];
    logic [pfan_pkg::COUNT_W-1:0]    r_o_count;
    logic [pfan_pkg::MAT_W-1:0]      r_o_mat;
    logic                            r_o_last;
    logic                            r_o_err;

    logic                            accept;
    logic                            closing;
    logic [pfan_pkg::INDEX_BITS-1:0] eff_pos;
    logic [pfan_pkg::FILL_W-1:0]     eff_fill;
    logic                            eff_ovf;
    logic                            full;
    logic [pfan_pkg::FILL_W-1:0]     n_after;
    logic                            ovf_after;
    logic [pfan_pkg::RAW_W-1:0]      vtx_raw;
    pfan_pkg::t_corner               new_corner;
    pfan_pkg::t_close_kind           kind;
    pfan_pkg::t_corner               rd_corner;
    logic                            out_free;

    assign accept   = i_in_valid && i_cmd.in_ready;
    assign closing  = i_raw_index[pfan_pkg::RAW_W-1];
    assign eff_pos  = i_start_of_mesh ? '0 : r_pos;
    assign eff_fill = i_start_of_mesh ? '0 : r_fill;
    assign eff_ovf  = i_start_of_mesh ? 1'b0 : r_ovf;
    assign full     = (eff_fill == pfan_pkg::FILL_W'(pfan_pkg::MAX_POLYGON_CORNERS));
    assign n_after  = full ? eff_fill : eff_fill + pfan_pkg::FILL_W'(1);
    assign ovf_after = eff_ovf || full;
    assign vtx_raw  = closing ? ~i_raw_index : i_raw_index;
    assign new_corner.pos = eff_pos;
    assign new_corner.vtx = vtx_raw[pfan_pkg::INDEX_BITS-1:0];
    assign out_free = !r_o_valid || i_out_ready;

    always_comb begin
        if (ovf_after || (!r_mode && n_after > pfan_pkg::FILL_W'(pfan_pkg::FACE_MAX))) begin
            kind = pfan_pkg::KIND_ERR;
        end else if (n_after >= pfan_pkg::FILL_W'(pfan_pkg::TRI_N)) begin
            kind = r_mode ? pfan_pkg::KIND_FAN : pfan_pkg::KIND_FACE;
        end else begin
            kind = pfan_pkg::KIND_DROP;
        end
    end

    assign o_status.close_fire = accept && closing;
    assign o_status.kind       = kind;
    assign o_status.fan_last   = (r_idx + pfan_pkg::FILL_W'(1)) == r_n;
    assign o_status.out_free   = out_free;

    pfan_ram #(
        .WIDTH($bits(pfan_pkg::t_corner)),
        .DEPTH(pfan_pkg::MAX_POLYGON_CORNERS)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (accept && !full),
        .i_wr_addr(eff_fill[pfan_pkg::ADDR_W-1:0]),
        .i_wr_data(new_corner),
        .i_rd_en  (i_cmd.rd_issue),
        .i_rd_addr(r_idx[pfan_pkg::ADDR_W-1:0]),
        .o_rd_data(rd_corner)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b1;
            r_pos     <= '0;
            r_fill    <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (accept) begin
                r_pos <= (eff_pos != '1) ? eff_pos + pfan_pkg::INDEX_BITS'(1) : eff_pos;
                if (closing) begin
                    r_fill <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_fill <= n_after;
                    r_ovf  <= ovf_after;
                end
            end
            if (i_cmd.load_fan || i_cmd.load_single) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int j = 0; j < pfan_pkg::FACE_MAX; j++) begin
                if (eff_fill == pfan_pkg::FILL_W'(j)) begin
                    r_c[j] <= new_corner;
                end
            end
        end
        if (accept && closing) begin
            r_n    <= n_after;
            r_err  <= (kind == pfan_pkg::KIND_ERR);
            r_mat  <= i_material;
            r_idx  <= pfan_pkg::FILL_W'(2);
            r_prev <= r_c[1];
        end
        if (i_cmd.load_fan) begin
            r_o_c[0]  <= r_c[0];
            r_o_c[1]  <= r_prev;
            r_o_c[2]  <= rd_corner;
            r_o_c[3]  <= '0;
            r_o_count <= pfan_pkg::COUNT_W'(pfan_pkg::TRI_N);
            r_o_mat   <= r_mat;
            r_o_last  <= o_status.fan_last;
            r_o_err   <= 1'b0;
            r_prev    <= rd_corner;
            r_idx     <= r_idx + pfan_pkg::FILL_W'(1);
        end else if (i_cmd.load_single) begin
            r_o_mat  <= r_mat;
            r_o_last <= 1'b1;
            r_o_err  <= r_err;
            if (r_err) begin
                for (int j = 0; j < pfan_pkg::FACE_MAX; j++) begin
                    r_o_c[j] <= '0;
                end
                r_o_count <= '0;
            end else begin
                r_o_c[0]  <= r_c[0];
                r_o_c[1]  <= r_c[1];
                r_o_c[2]  <= r_c[2];
                r_o_c[3]  <= (r_n == pfan_pkg::FILL_W'(pfan_pkg::FACE_MAX)) ? r_c[3] : '0;
                r_o_count <= r_n[pfan_pkg::COUNT_W-1:0];
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_last  = r_o_last;
    assign o_out_error = r_o_err;
    assign o_out_data  = pfan_pkg::OUT_TDATA_W'({r_o_mat, r_o_count,
        r_o_c[3].vtx, r_o_c[2].vtx, r_o_c[1].vtx, r_o_c[0].vtx,
        r_o_c[3].pos, r_o_c[2].pos, r_o_c[1].pos, r_o_c[0].pos});

endmodule

>>> sv/polygon_fan_triangulator_top.sv
// Top level of the polygon fan triangulator: joins controller and datapath.
// Depends on pfan_pkg, pfan_ctrl, pfan_datapath and pfan_ram.
//
//   Channel   Direction  Handshake                     Carries
//   s_axis    in         s_axis_tvalid/s_axis_tready   index entries
//   m_axis    out        m_axis_tvalid/m_axis_tready   faces or triangles
//   cfg       in         i_cfg_valid/o_cfg_ready       triangulate_mode
//
// An entry that does not close a polygon, or closes a dropped short polygon, is
// taken in S_TAKE alone. A single face or error result adds the S_SINGLE state. A
// fan visits, per triangle, S_READ for the registered read of the corner RAM and
// then S_FAN for the output register load. A full output register stalls result
// loads, and intake waits while a result is pending. Reset needs no clearing pass.
module polygon_fan_triangulator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // raw_index, material, zero fill.
    input  logic [pfan_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // start_of_mesh.
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // corner0..3_position, corner0..3_vertex, corner_count, face_material, zero fill.
    output logic [pfan_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // polygon_error.
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);

    pfan_pkg::t_dp_cmd    cmd;
    pfan_pkg::t_dp_status status;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = cmd.in_ready;

    pfan_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_status(status),
        .o_cmd   (cmd)
    );

    pfan_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (s_axis_tvalid),
        .i_raw_index    (s_axis_tdata[pfan_pkg::RAW_W-1:0]),
        .i_material     (s_axis_tdata[pfan_pkg::RAW_W +: pfan_pkg::MAT_W]),
        .i_start_of_mesh(s_axis_tuser),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_data     (m_axis_tdata),
        .o_out_last     (m_axis_tlast),
        .o_out_error    (m_axis_tuser)
    );

endmodule

>>> tb/tb_polygon_fan_triangulator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for polygon_fan_triangulator_top: streams polygon index entries,
// predicts every fan triangle, face and error beat, and compares them field by field.
// Depends on pfan_pkg and the polygon_fan_triangulator_top RTL.
module tb_polygon_fan_triangulator_top;

    localparam int  CLK_HALF    = 6;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  SETTLE      = 16;
    localparam int  HOLD_CYCLES = 400;
    localparam int  PHASE_ITEMS = 30;
    localparam int  PAD_W       = pfan_pkg::IN_TDATA_W - pfan_pkg::RAW_W - pfan_pkg::MAT_W;
    localparam bit  MODE_FAN    = 1'b1;
    localparam bit  MODE_FACE   = 1'b0;

    typedef struct packed {
        logic [pfan_pkg::FACE_MAX-1:0][pfan_pkg::INDEX_BITS-1:0] pos;
        logic [pfan_pkg::FACE_MAX-1:0][pfan_pkg::INDEX_BITS-1:0] vtx;
        logic [pfan_pkg::COUNT_W-1:0]                            count;
        logic [pfan_pkg::MAT_W-1:0]                              mat;
        logic                                                    last;
        logic                                                    err;
    } t_face;

    typedef enum logic {
        ROW_ENTRY,
        ROW_MODE
    } t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        logic [pfan_pkg::RAW_W-1:0] raw;
        logic [pfan_pkg::MAT_W-1:0] mat;
        logic                       som;
        int                         reps;
        bit                         typed;
        t_face                      want;
    } t_stim_row;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_valid   = 1'b0;
    logic                             i_cfg_data    = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic [pfan_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             s_axis_tuser  = 1'b0;
    logic                             m_axis_tready = 1'b0;
    logic                             o_cfg_ready;
    logic                             s_axis_tready;
    logic                             m_axis_tvalid;
    logic [pfan_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             m_axis_tlast;

    logic [pfan_pkg::INDEX_BITS-1:0]  corner_pos [pfan_pkg::MAX_POLYGON_CORNERS];
    logic [pfan_pkg::INDEX_BITS-1:0]  corner_vtx [pfan_pkg::MAX_POLYGON_CORNERS];
    int                               corner_fill;
    logic [pfan_pkg::INDEX_BITS-1:0]  next_position;
    bit                               overflow_mark;
    bit                               fan_mode;

    t_face      faces_due [$];
    t_face      new_faces [$];
    t_stim_row  stim_rows [$];
    int         items_sent  = 0;
    int         error_count = 0;
    int         cycle_count = 0;
    bit         quiet       = 1'b0;
    bit         hold_req    = 1'b0;

    polygon_fan_triangulator_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_face face_lit(input int cnt, input int p0, input int p1, input int p2,
                                       input int v0, input int v1, input int v2,
                                       input int mat, input bit err);
        t_face f;
        f        = '0;
        f.pos[0] = p0[pfan_pkg::INDEX_BITS-1:0];
        f.pos[1] = p1[pfan_pkg::INDEX_BITS-1:0];
        f.pos[2] = p2[pfan_pkg::INDEX_BITS-1:0];
        f.vtx[0] = v0[pfan_pkg::INDEX_BITS-1:0];
        f.vtx[1] = v1[pfan_pkg::INDEX_BITS-1:0];
        f.vtx[2] = v2[pfan_pkg::INDEX_BITS-1:0];
        f.count  = cnt[pfan_pkg::COUNT_W-1:0];
        f.mat    = mat[pfan_pkg::MAT_W-1:0];
        f.last   = 1'b1;
        f.err    = err;
        return f;
    endfunction

    function automatic t_face error_face(input int mat);
        return face_lit(0, 0, 0, 0, 0, 0, 0, mat, 1'b1);
    endfunction

    function automatic t_face unpack_face(input logic [pfan_pkg::OUT_TDATA_W-1:0] d,
                                          input logic last, input logic err);
        t_face f;
        for (int j = 0; j < pfan_pkg::FACE_MAX; j++) begin
            f.pos[j] = d[j*pfan_pkg::INDEX_BITS +: pfan_pkg::INDEX_BITS];
            f.vtx[j] = d[(pfan_pkg::FACE_MAX+j)*pfan_pkg::INDEX_BITS +: pfan_pkg::INDEX_BITS];
        end
        f.count = d[2*pfan_pkg::FACE_MAX*pfan_pkg::INDEX_BITS +: pfan_pkg::COUNT_W];
        f.mat   = d[2*pfan_pkg::FACE_MAX*pfan_pkg::INDEX_BITS+pfan_pkg::COUNT_W +:
                    pfan_pkg::MAT_W];
        f.last  = last;
        f.err   = err;
        return f;
    endfunction

    task automatic clear_model();
        corner_fill   = 0;
        next_position = '0;
        overflow_mark = 1'b0;
        fan_mode      = MODE_FAN;
    endtask

    task automatic fan_out_entry(input logic [pfan_pkg::RAW_W-1:0] raw,
                                 input logic [pfan_pkg::MAT_W-1:0] mat, input logic som);
        logic [pfan_pkg::INDEX_BITS-1:0] here;
        logic [pfan_pkg::INDEX_BITS-1:0] vertex;
        t_face                           f;
        bit                              closing;
        closing = raw[pfan_pkg::RAW_W-1];
        new_faces.delete();
        if (som) begin
            next_position = '0;
            corner_fill   = 0;
            overflow_mark = 1'b0;
        end
        here = next_position;
        if (next_position != '1) next_position = next_position + 1'b1;
        vertex = closing ? ~raw[pfan_pkg::INDEX_BITS-1:0] : raw[pfan_pkg::INDEX_BITS-1:0];
        if (corner_fill < pfan_pkg::MAX_POLYGON_CORNERS) begin
            corner_pos[corner_fill] = here;
            corner_vtx[corner_fill] = vertex;
            corner_fill++;
        end else begin
            overflow_mark = 1'b1;
        end
        if (closing) begin
            if (overflow_mark ||
                (fan_mode == MODE_FACE && corner_fill > pfan_pkg::FACE_MAX)) begin
                new_faces.push_back(error_face(mat));
            end else if (corner_fill >= pfan_pkg::TRI_N) begin
                if (fan_mode == MODE_FAN) begin
                    for (int i = 2; i < corner_fill; i++) begin
                        f        = '0;
                        f.pos[0] = corner_pos[0];
                        f.pos[1] = corner_pos[i-1];
                        f.pos[2] = corner_pos[i];
                        f.vtx[0] = corner_vtx[0];
                        f.vtx[1] = corner_vtx[i-1];
                        f.vtx[2] = corner_vtx[i];
                        f.count  = pfan_pkg::COUNT_W'(pfan_pkg::TRI_N);
                        f.mat    = mat;
                        f.last   = (i == corner_fill - 1);
                        new_faces.push_back(f);
                    end
                end else begin
                    f = '0;
                    for (int j = 0; j < corner_fill; j++) begin
                        f.pos[j] = corner_pos[j];
                        f.vtx[j] = corner_vtx[j];
                    end
                    f.count = corner_fill[pfan_pkg::COUNT_W-1:0];
                    f.mat   = mat;
                    f.last  = 1'b1;
                    new_faces.push_back(f);
                end
            end
            corner_fill   = 0;
            overflow_mark = 1'b0;
        end
    endtask

    task automatic send_entry(input logic [pfan_pkg::RAW_W-1:0] raw,
                              input logic [pfan_pkg::MAT_W-1:0] mat,
                              input logic som, input bit typed, input t_face want);
        s_axis_tdata  <= {{PAD_W{1'b0}}, mat, raw};
        s_axis_tuser  <= som;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        fan_out_entry(raw, mat, som);
        if (typed) begin
            faces_due.push_back(want);
        end else begin
            foreach (new_faces[k]) faces_due.push_back(new_faces[k]);
        end
        items_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (faces_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit mode);
        wait_drained();
        i_cfg_data  <= mode;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        fan_mode = mode;
    endtask

    task automatic add_row(input t_row_kind kind, input int raw_val, input int mat,
                           input logic som, input int reps, input bit typed, input t_face want);
        t_stim_row r;
        r.kind  = kind;
        r.raw   = raw_val[pfan_pkg::RAW_W-1:0];
        r.mat   = mat[pfan_pkg::MAT_W-1:0];
        r.som   = som;
        r.reps  = reps;
        r.typed = typed;
        r.want  = want;
        stim_rows.push_back(r);
    endtask

    function automatic logic [pfan_pkg::INDEX_BITS-1:0] rand_vertex();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return pfan_pkg::INDEX_BITS'($urandom());
    endfunction

    task automatic send_polygon(input int n);
        logic [pfan_pkg::INDEX_BITS-1:0] v;
        logic [pfan_pkg::RAW_W-1:0]      raw;
        logic                            som;
        for (int k = 0; k < n; k++) begin
            v   = rand_vertex();
            raw = (k == n - 1) ? {1'b1, ~v} : {1'b0, v};
            som = (k == 0) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 49) == 0);
            send_entry(raw, pfan_pkg::MAT_W'($urandom_range(0, 255)), som, 1'b0, '0);
        end
    endtask

    task automatic random_phase(input bit mode, input int budget);
        int target;
        int pick;
        target = items_sent + budget;
        write_mode(mode);
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_polygon($urandom_range(1, 2));
            end else if (pick < 12) begin
                send_polygon($urandom_range(62, 67));
            end else if (pick < 17) begin
                send_entry(pfan_pkg::RAW_W'($urandom()),
                           pfan_pkg::MAT_W'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 1'b0, '0);
            end else if (mode == MODE_FAN) begin
                send_polygon($urandom_range(3, 10));
            end else if (pick < 80) begin
                send_polygon($urandom_range(3, 4));
            end else begin
                send_polygon($urandom_range(5, 7));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic compare_face(input t_face want, input t_face got);
        for (int j = 0; j < pfan_pkg::FACE_MAX; j++) begin
            check_field($sformatf("corner%0d_position", j), want.pos[j], got.pos[j]);
            check_field($sformatf("corner%0d_vertex", j), want.vtx[j], got.vtx[j]);
        end
        check_field("corner_count", want.count, got.count);
        check_field("face_material", want.mat, got.mat);
        check_field("last_of_polygon", want.last, got.last);
        check_field("polygon_error", want.err, got.err);
    endtask

    initial begin
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                if (faces_due.size() == 0) begin
                    $display("%0t: unexpected beat, expected none actual %h", $time,
                             m_axis_tdata);
                    error_count++;
                end else begin
                    compare_face(faces_due.pop_front(),
                                 unpack_face(m_axis_tdata, m_axis_tlast, m_axis_tuser));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done     = 1'b1;
                stall_left    = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left    = $urandom_range(1, 18) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        clear_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fan mode is the reset setting.
        add_row(ROW_ENTRY, 5, 0, 1'b1, 1, 1'b0, '0);
        add_row(ROW_ENTRY, 7, 0, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, -10, 'h11, 1'b0, 1, 1'b1, face_lit(3, 0, 1, 2, 5, 7, 9, 'h11, 1'b0));
        add_row(ROW_ENTRY, 0, 0, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, 16777215, 'hFF, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, 'h800000, 0, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, -16777216, 'hFF, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, -1, 0, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, 3, 0, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, -5, 'h42, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, 1, 0, 1'b0, 70, 1'b0, '0);
        add_row(ROW_ENTRY, -2, 'hA5, 1'b0, 1, 1'b1, error_face('hA5));
        add_row(ROW_ENTRY, 9, 0, 1'b0, 63, 1'b0, '0);
        add_row(ROW_ENTRY, -4, 'h81, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, 11, 0, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, 12, 0, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, 13, 0, 1'b1, 1, 1'b0, '0);
        add_row(ROW_ENTRY, 14, 0, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, -16, 3, 1'b0, 1, 1'b1, face_lit(3, 0, 1, 2, 13, 14, 15, 3, 1'b0));
        add_row(ROW_MODE, MODE_FACE, 0, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, 20, 0, 1'b0, 2, 1'b0, '0);
        add_row(ROW_ENTRY, -23, 'h5A, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, 30, 0, 1'b0, 3, 1'b0, '0);
        add_row(ROW_ENTRY, -34, 'hC3, 1'b0, 1, 1'b0, '0);
        add_row(ROW_ENTRY, 40, 0, 1'b0, 4, 1'b0, '0);
        add_row(ROW_ENTRY, -45, 'h3C, 1'b0, 1, 1'b1, error_face('h3C));
        add_row(ROW_ENTRY, 50, 0, 1'b0, 66, 1'b0, '0);
        add_row(ROW_ENTRY, -3, 'h7E, 1'b0, 1, 1'b1, error_face('h7E));
        add_row(ROW_MODE, MODE_FAN, 0, 1'b0, 1, 1'b0, '0);

        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_MODE) begin
                write_mode(stim_rows[r].raw[0]);
            end else begin
                for (int k = 0; k < stim_rows[r].reps; k++) begin
                    send_entry(stim_rows[r].raw, stim_rows[r].mat, stim_rows[r].som,
                               stim_rows[r].typed, stim_rows[r].want);
                end
            end
        end

        hold_req = 1'b1;
        random_phase(MODE_FAN, PHASE_ITEMS);
        random_phase(MODE_FACE, PHASE_ITEMS);
        random_phase(MODE_FAN, PHASE_ITEMS);
        quiet = 1'b1;
        random_phase(MODE_FACE, PHASE_ITEMS);
        wait_drained();

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/pfan_pkg.sv
sv/pfan_ram.sv
sv/pfan_ctrl.sv
sv/pfan_datapath.sv
sv/polygon_fan_triangulator_top.sv
tb/tb_polygon_fan_triangulator_top.sv
